FILE: sv/kcps_pkg.sv
package kcps_pkg;

   // point store capacity
   localparam int MAX_POINTS = 64;
   localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);

   // field widths
   localparam int ID_W    = 16;
   localparam int POS_W   = 24;
   localparam int AXIS_W  = 24;              // |difference| of two 24 bit values
   localparam int SQ_W    = 2 * AXIS_W;
   localparam int DIST_W  = SQ_W + 2;        // sum of three squares
   localparam int ENTRY_W = ID_W + DIST_W;
   localparam int TGT_W   = 7;
   localparam int CMP_W   = (CNT_W > TGT_W) ? CNT_W : TGT_W;

   localparam logic [TGT_W-1:0] RESULT_CAP = TGT_W'(64);

   // stream word layout
   localparam int REQ_DATA_W = ID_W + 3 * POS_W;
   localparam int RSP_DATA_W = ID_W;
   localparam int RSP_USER_W = 2;
   localparam int RSP_USER_VALID = 0;
   localparam int RSP_USER_OVF   = 1;

   // register file
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 24;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_TARGETS = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ORIGIN_X    = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_ORIGIN_Y    = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_ORIGIN_Z    = 2'd3;

   typedef struct packed {
      logic                    start;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic signed [POS_W-1:0] org_x;
      logic signed [POS_W-1:0] org_y;
      logic signed [POS_W-1:0] org_z;
   } dist_req_type;

   typedef struct packed {
      logic              done;
      logic [DIST_W-1:0] dist_sq;
   } dist_rsp_type;

endpackage

FILE: sv/kcps_ram.sv
module kcps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [ADDR_W-1:0]        waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [ADDR_W-1:0]        raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: sv/kcps_dist_unit.sv
module kcps_dist_unit
   import kcps_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  dist_req_type req,
   output dist_rsp_type rsp
);

   logic              busy_ff;
   logic [1:0]        step_ff;
   logic              done_ff;
   logic [AXIS_W-1:0] ax_ff, ay_ff, az_ff;
   logic [SQ_W-1:0]   prod_ff;
   logic [DIST_W-1:0] acc_ff;
   logic [AXIS_W-1:0] mul_op;

   function automatic logic [AXIS_W-1:0] abs_diff(logic signed [POS_W-1:0] p,
                                                  logic signed [POS_W-1:0] o);
      logic signed [POS_W:0] d;
      logic signed [POS_W:0] a;
      d = {p[POS_W-1], p} - {o[POS_W-1], o};
      a = d[POS_W] ? -d : d;
      return a[AXIS_W-1:0];
   endfunction

   // one squarer, fed one axis per step
   always_comb begin
      unique case (step_ff)
         2'd0:    mul_op = ax_ff;
         2'd1:    mul_op = ay_ff;
         2'd2:    mul_op = az_ff;
         default: mul_op = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (step_ff == 2'd3);
         if (req.start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
            ax_ff   <= abs_diff(req.pos_x, req.org_x);
            ay_ff   <= abs_diff(req.pos_y, req.org_y);
            az_ff   <= abs_diff(req.pos_z, req.org_z);
         end else if (busy_ff) begin
            step_ff <= step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               busy_ff <= 1'b0;
            end
            prod_ff <= SQ_W'(mul_op) * SQ_W'(mul_op);
            // accumulate the product registered in the previous step
            if (step_ff == 2'd0) begin
               acc_ff <= '0;
            end else begin
               acc_ff <= acc_ff + DIST_W'(prod_ff);
            end
         end
      end
   end

   assign rsp.done    = done_ff;
   assign rsp.dist_sq = acc_ff;

endmodule

FILE: sv/k_closest_point_select_core.sv
// Nearest-point selector. Load a set of points, one word each (id and signed
// Q19.4 x,y,z), with tlast on the final point. Each stored point keeps the
// squared distance to the origin registers as they stand when it is loaded;
// one shared 24x24 squarer works the three axes in turn, and the next word is
// not taken until that point's distance is done. Up to MAX_POINTS (64)
// points are kept; more are dropped and flagged in overflowed on every
// result of that set. After the final point the block answers from a 64
// entry store with a registered read port: a set no larger than max_targets
// (saturated at 64) comes back in load order, otherwise each result costs
// one pass over the store, giving ids nearest first, ties to the earliest
// loaded, each id at most once. max_targets of zero gives a single word with
// valid_target low. Configuration must be written between sets only; the
// block itself does not enforce this.
module k_closest_point_select_core
   import kcps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // point_id[15:0], pos_x[39:16], pos_y[63:40], pos_z[87:64]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // target_id[15:0]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // valid_target[0], overflowed[1]
   output logic [RSP_USER_W-1:0] rsp_tuser,
   output logic                  rsp_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_DIST   = 4'd1;
   localparam logic [3:0] ST_SEL    = 4'd2;
   localparam logic [3:0] ST_ORD_RD = 4'd3;
   localparam logic [3:0] ST_ORD_EM = 4'd4;
   localparam logic [3:0] ST_SCAN   = 4'd5;
   localparam logic [3:0] ST_DECIDE = 4'd6;
   localparam logic [3:0] ST_FLUSH  = 4'd7;
   localparam logic [3:0] ST_FINISH = 4'd8;

   logic [3:0]              state_ff, state_in;

   logic [TGT_W-1:0]        max_targets_ff;
   logic [POS_W-1:0]        origin_x_ff, origin_y_ff, origin_z_ff;

   logic [CNT_W-1:0]        count_ff;
   logic                    ovf_ff;
   logic [MAX_POINTS-1:0]   picked_ff;
   logic [ID_W-1:0]         id_ff;
   logic                    last_ff;

   logic [CNT_W-1:0]        rd_idx_ff;
   logic                    cmp_v_ff;
   logic [IDX_W-1:0]        cmp_idx_ff;
   logic                    found_ff;
   logic [DIST_W-1:0]       best_dist_ff;
   logic [ID_W-1:0]         best_id_ff;
   logic                    prev_v_ff;
   logic [ID_W-1:0]         prev_id_ff;
   logic                    pend_v_ff;
   logic [ID_W-1:0]         pend_id_ff;
   logic [TGT_W-1:0]        k_ff;

   logic                    rsp_valid_ff;
   logic [ID_W-1:0]         rsp_id_ff;
   logic                    rsp_vt_ff;
   logic                    rsp_ovf_ff;
   logic                    rsp_last_ff;

   logic                    req_acc;
   logic                    out_free;
   logic                    emit_en;
   logic [ID_W-1:0]         emit_id;
   logic                    emit_vt;
   logic                    emit_last;
   logic [TGT_W-1:0]        eff;
   logic [TGT_W-1:0]        k_next;
   logic                    rd_more;
   logic                    ord_last;
   logic                    full;
   logic                    same_id;
   logic                    skip;

   logic                    ram_re;
   logic [ENTRY_W-1:0]      ram_q;
   logic [ID_W-1:0]         rd_id;
   logic [DIST_W-1:0]       rd_dist;

   dist_req_type            dist_req;
   dist_rsp_type            dist_rsp;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign full       = (count_ff == CNT_W'(MAX_POINTS));
   assign eff        = (max_targets_ff > RESULT_CAP) ? RESULT_CAP : max_targets_ff;
   assign k_next     = k_ff + TGT_W'(1);
   assign rd_more    = (rd_idx_ff < count_ff);
   assign ord_last   = (CNT_W'(rd_idx_ff + CNT_W'(1)) == count_ff);
   assign rd_id      = ram_q[ENTRY_W-1:DIST_W];
   assign rd_dist    = ram_q[DIST_W-1:0];
   assign same_id    = prev_v_ff && (rd_id == prev_id_ff);
   assign skip       = picked_ff[cmp_idx_ff] || same_id;

   assign dist_req.start = (state_ff == ST_IDLE) && req_acc && !full;
   assign dist_req.pos_x = req_tdata[ID_W +: POS_W];
   assign dist_req.pos_y = req_tdata[ID_W + POS_W +: POS_W];
   assign dist_req.pos_z = req_tdata[ID_W + 2 * POS_W +: POS_W];
   assign dist_req.org_x = origin_x_ff;
   assign dist_req.org_y = origin_y_ff;
   assign dist_req.org_z = origin_z_ff;

   kcps_dist_unit u_dist (
      .clock (clock),
      .reset (reset),
      .req   (dist_req),
      .rsp   (dist_rsp)
   );

   kcps_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_POINTS)
   ) u_store (
      .clock (clock),
      .we    (dist_rsp.done),
      .waddr (count_ff[IDX_W-1:0]),
      .wdata ({id_ff, dist_rsp.dist_sq}),
      .re    (ram_re),
      .raddr (rd_idx_ff[IDX_W-1:0]),
      .rdata (ram_q)
   );

   always_comb begin
      state_in  = state_ff;
      emit_en   = 1'b0;
      emit_id   = '0;
      emit_vt   = 1'b0;
      emit_last = 1'b0;
      ram_re    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (!full) begin
                  state_in = ST_DIST;
               end else if (req_tlast) begin
                  state_in = ST_SEL;
               end
            end
         end
         ST_DIST: begin
            if (dist_rsp.done) begin
               state_in = last_ff ? ST_SEL : ST_IDLE;
            end
         end
         ST_SEL: begin
            if (eff == '0) begin
               if (out_free) begin
                  emit_en   = 1'b1;
                  emit_last = 1'b1;
                  state_in  = ST_FINISH;
               end
            end else if (CMP_W'(count_ff) <= CMP_W'(eff)) begin
               state_in = ST_ORD_RD;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_ORD_RD: begin
            ram_re   = 1'b1;
            state_in = ST_ORD_EM;
         end
         ST_ORD_EM: begin
            if (out_free) begin
               emit_en   = 1'b1;
               emit_id   = rd_id;
               emit_vt   = 1'b1;
               emit_last = ord_last;
               state_in  = ord_last ? ST_FINISH : ST_ORD_RD;
            end
         end
         ST_SCAN: begin
            ram_re = rd_more;
            if (!rd_more && !cmp_v_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            // hold the newest pick back until the next pass shows whether it is the last
            if (!found_ff) begin
               state_in = ST_FLUSH;
            end else if (!pend_v_ff || out_free) begin
               emit_en  = pend_v_ff;
               emit_id  = pend_id_ff;
               emit_vt  = 1'b1;
               state_in = (k_next == eff) ? ST_FLUSH : ST_SCAN;
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               emit_en   = 1'b1;
               emit_id   = pend_id_ff;
               emit_vt   = 1'b1;
               emit_last = 1'b1;
               state_in  = ST_FINISH;
            end
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         max_targets_ff <= TGT_W'(1);
         origin_x_ff    <= '0;
         origin_y_ff    <= '0;
         origin_z_ff    <= '0;
         count_ff       <= '0;
         ovf_ff         <= 1'b0;
         picked_ff      <= '0;
         rd_idx_ff      <= '0;
         cmp_v_ff       <= 1'b0;
         found_ff       <= 1'b0;
         prev_v_ff      <= 1'b0;
         pend_v_ff      <= 1'b0;
         k_ff           <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_we) begin
            unique case (csr_addr)
               CSR_MAX_TARGETS: max_targets_ff <= csr_wdata[TGT_W-1:0];
               CSR_ORIGIN_X:    origin_x_ff    <= csr_wdata[POS_W-1:0];
               CSR_ORIGIN_Y:    origin_y_ff    <= csr_wdata[POS_W-1:0];
               CSR_ORIGIN_Z:    origin_z_ff    <= csr_wdata[POS_W-1:0];
               default:         ;
            endcase
         end

         if (emit_en) begin
            rsp_valid_ff <= 1'b1;
            rsp_id_ff    <= emit_id;
            rsp_vt_ff    <= emit_vt;
            rsp_ovf_ff   <= ovf_ff;
            rsp_last_ff  <= emit_last;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_acc) begin
                  id_ff   <= req_tdata[ID_W-1:0];
                  last_ff <= req_tlast;
                  if (full) begin
                     ovf_ff <= 1'b1;
                  end
               end
            end
            ST_DIST: begin
               if (dist_rsp.done) begin
                  count_ff <= count_ff + CNT_W'(1);
               end
            end
            ST_SEL: begin
               rd_idx_ff <= '0;
               cmp_v_ff  <= 1'b0;
               found_ff  <= 1'b0;
               prev_v_ff <= 1'b0;
               pend_v_ff <= 1'b0;
               k_ff      <= '0;
            end
            ST_ORD_EM: begin
               if (out_free) begin
                  rd_idx_ff <= rd_idx_ff + CNT_W'(1);
               end
            end
            ST_SCAN: begin
               if (rd_more) begin
                  rd_idx_ff <= rd_idx_ff + CNT_W'(1);
               end
               cmp_v_ff   <= rd_more;
               cmp_idx_ff <= rd_idx_ff[IDX_W-1:0];
               if (cmp_v_ff) begin
                  // entries sharing the last picked id drop out for good
                  if (same_id) begin
                     picked_ff[cmp_idx_ff] <= 1'b1;
                  end
                  if (!skip && (!found_ff || (rd_dist < best_dist_ff))) begin
                     found_ff     <= 1'b1;
                     best_dist_ff <= rd_dist;
                     best_id_ff   <= rd_id;
                  end
               end
            end
            ST_DECIDE: begin
               if (found_ff && (!pend_v_ff || out_free)) begin
                  pend_v_ff  <= 1'b1;
                  pend_id_ff <= best_id_ff;
                  prev_v_ff  <= 1'b1;
                  prev_id_ff <= best_id_ff;
                  k_ff       <= k_next;
                  rd_idx_ff  <= '0;
                  cmp_v_ff   <= 1'b0;
                  found_ff   <= 1'b0;
               end
            end
            ST_FINISH: begin
               count_ff  <= '0;
               picked_ff <= '0;
               ovf_ff    <= 1'b0;
            end
            default: ;
         endcase
      end
   end

   assign rsp_tvalid                = rsp_valid_ff;
   assign rsp_tdata                 = rsp_id_ff;
   assign rsp_tuser[RSP_USER_VALID] = rsp_vt_ff;
   assign rsp_tuser[RSP_USER_OVF]   = rsp_ovf_ff;
   assign rsp_tlast                 = rsp_last_ff;

endmodule

FILE: sv/kcps_checker.sv
module kcps_checker
   import kcps_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [RSP_USER_W-1:0] rsp_tuser,
   input logic                  rsp_tlast,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   // an empty answer ends its query
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[RSP_USER_VALID] |-> rsp_tlast)
      else $error("result without target not marked last");

   // an empty answer carries a zero id
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[RSP_USER_VALID] |-> rsp_tdata == '0)
      else $error("result without target carries an id");

   // nothing is offered straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

endmodule

bind k_closest_point_select_core kcps_checker u_kcps_checker (.*);
